/* hw/rtl/esad_pkg.sv */
// Shared types and constants for the EMA k-sigma anomaly detector.
`timescale 1ns / 1ps
`default_nettype none

package esad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_SH  = 12;
  localparam int MEAN_W   = 28;
  localparam int VAR_W    = 40;
  localparam int GAIN_W   = 16;
  localparam int ROOT_W   = 20;
  localparam int K_W      = 4;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_W    = 28;
  localparam int PROD_W   = 2 * MUL_W;

  localparam logic [VAR_W-1:0]    VAR_ONE         = 40'h00_0001_0000;
  localparam logic [SAMPLE_W-1:0] THRESH_RESET    = 16'd80;
  localparam logic [CNT_W-1:0]    WARMUP_RESET    = 8'd48;
  localparam logic [GAIN_W-1:0]   FAST_GAIN_RESET = 16'd6554;
  localparam logic [GAIN_W-1:0]   SLOW_GAIN_RESET = 16'd1311;
  localparam logic [K_W-1:0]      K_RESET         = 4'd4;
  localparam logic [SAMPLE_W-1:0] FLOOR_RESET     = 16'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARMUP_COUNT     = 3'd0,
    CFG_FAST_GAIN        = 3'd1,
    CFG_SLOW_GAIN        = 3'd2,
    CFG_SIGMA_MULTIPLIER = 3'd3,
    CFG_THRESHOLD_FLOOR  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_E2,
    S_MEAN,
    S_VDIFF,
    S_VLO,
    S_VHI,
    S_VUPD,
    S_SQ_GO,
    S_SQ_WAIT,
    S_KMUL,
    S_THR,
    S_DONE
  } esad_state_t;

endpackage

`default_nettype wire

/* hw/rtl/esad_isqrt.sv */
// Iterative floor square root of the 40-bit variance, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module esad_isqrt import esad_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [VAR_W-1:0]  radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int CNT_BITS = $clog2(ROOT_W);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(ROOT_W - 1);
  localparam logic [VAR_W-1:0] TOP_BIT = VAR_W'(1) << (2 * (ROOT_W - 1));

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [VAR_W-1:0]    rem;
  logic [VAR_W-1:0]    res;
  logic [VAR_W-1:0]    bitv;
  logic [VAR_W-1:0]    trial;

  assign trial = res + bitv;
  assign done  = busy && (cnt == '0);
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= LAST_STEP;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitv <= TOP_BIT;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ema_sigma_anomaly_detector_core.sv */
// Top level of the EMA mean/variance k-sigma anomaly detector.
// Each accepted sample updates an exponential mean and variance through one
// shared 28x28 multiplier under a small sequencer, then (after warm-up, or on
// the last warm-up sample) rebuilds the threshold mean + k*sqrt(variance),
// saturated and raised to the floor, with an iterative root that yields one
// bit per cycle. A sample in steady state, and the last warm-up sample, runs
// 6 multiply/update steps, root start, 20 root steps, scale, threshold and
// load; a middle warm-up sample runs the update steps and the load, the first
// warm-up sample only the load (root start through load when it is also the
// last). The input reopens the cycle after the load, which waits while the
// output register is stalled. The input is stalled while a sample is in work;
// the finished result sits in an output register, and a new sample may be
// accepted while it waits. Configuration writes are always ready and must be
// issued only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module ema_sigma_anomaly_detector_core import esad_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_W-1:0]   sample,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       alarm,
  output logic                       learned,
  output logic [SAMPLE_W-1:0]        threshold_out,
  output logic [SAMPLE_W-1:0]        mean_out,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [CNT_W-1:0]    warmup_count;
  logic [GAIN_W-1:0]   fast_gain;
  logic [GAIN_W-1:0]   slow_gain;
  logic [K_W-1:0]      sigma_multiplier;
  logic [SAMPLE_W-1:0] threshold_floor;

  // statistics
  logic [MEAN_W-1:0]   mean;
  logic [VAR_W-1:0]    variance;
  logic [SAMPLE_W-1:0] thresh;
  logic [CNT_W-1:0]    wcnt;

  // per-sample work registers
  esad_state_t         state, state_next;
  logic [SAMPLE_W-1:0] sample_r;
  logic [GAIN_W-1:0]   gain;
  logic [MEAN_W-1:0]   mag;
  logic                mean_up;
  logic [VAR_W-1:0]    e2;
  logic [VAR_W-1:0]    vd;
  logic                var_up;
  logic [ROOT_W-1:0]   vlo_hi;
  logic                steady;
  logic                need_thr;
  logic                alarm_r;
  logic [PROD_W-1:0]   prod;

  // control
  logic                in_take;
  logic                out_free;
  logic                sq_start;
  logic                sq_done;
  logic [ROOT_W-1:0]   sq_root;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;

  // accept-time decode
  logic [MEAN_W-1:0]   x;
  logic                warm;
  logic                first;
  logic                need_thr_c;

  // datapath helpers
  logic [VAR_W-1:0]    vstep;
  logic [MEAN_W+5-1:0] tsum;
  logic [SAMPLE_W-1:0] tsat;
  logic [SAMPLE_W-1:0] tfin;

  assign x          = {sample, {FRAC_SH{1'b0}}};
  assign warm       = wcnt < warmup_count;
  assign first      = warm && (wcnt == '0);
  assign need_thr_c = !warm || ((wcnt + 1'b1) == warmup_count);
  assign in_take    = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  assign vstep = {prod[VAR_W-ROOT_W+GAIN_W-1:0], 4'b0} + {{(VAR_W-ROOT_W){1'b0}}, vlo_hi};
  assign tsum  = {5'b0, mean} + {1'b0, prod[ROOT_W+K_W-1:0], 8'b0};
  assign tsat  = (tsum[MEAN_W+5-1:FRAC_SH+SAMPLE_W] != '0) ? {SAMPLE_W{1'b1}}
               : tsum[FRAC_SH+SAMPLE_W-1:FRAC_SH];
  assign tfin  = (tsat < threshold_floor) ? threshold_floor : tsat;

  esad_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (variance),
    .done     (sq_done),
    .root     (sq_root)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (first) begin
            state_next = need_thr_c ? S_SQ_GO : S_DONE;
          end else begin
            state_next = S_E2;
          end
        end
      end
      S_E2:      state_next = S_MEAN;
      S_MEAN:    state_next = S_VDIFF;
      S_VDIFF:   state_next = S_VLO;
      S_VLO:     state_next = S_VHI;
      S_VHI:     state_next = S_VUPD;
      S_VUPD:    state_next = need_thr ? S_SQ_GO : S_DONE;
      S_SQ_GO:   state_next = S_SQ_WAIT;
      S_SQ_WAIT: state_next = sq_done ? S_KMUL : S_SQ_WAIT;
      S_KMUL:    state_next = S_THR;
      S_THR:     state_next = S_DONE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control outputs and multiplier operand select
  always_comb begin
    in_stall = (state != S_IDLE);
    out_free = !out_valid || !out_stall;
    sq_start = (state == S_SQ_GO);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_E2: begin
        mul_a = mag;
        mul_b = mag;
      end
      S_MEAN: begin
        mul_a = mag;
        mul_b = MUL_W'(gain);
      end
      S_VLO: begin
        mul_a = MUL_W'(vd[ROOT_W-1:0]);
        mul_b = MUL_W'(gain);
      end
      S_VHI: begin
        mul_a = MUL_W'(vd[VAR_W-1:ROOT_W]);
        mul_b = MUL_W'(gain);
      end
      S_KMUL: begin
        mul_a = MUL_W'(sq_root);
        mul_b = MUL_W'(sigma_multiplier);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_count     <= WARMUP_RESET;
      fast_gain        <= FAST_GAIN_RESET;
      slow_gain        <= SLOW_GAIN_RESET;
      sigma_multiplier <= K_RESET;
      threshold_floor  <= FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WARMUP_COUNT:     warmup_count     <= cfg_data[CNT_W-1:0];
        CFG_FAST_GAIN:        fast_gain        <= cfg_data[GAIN_W-1:0];
        CFG_SLOW_GAIN:        slow_gain        <= cfg_data[GAIN_W-1:0];
        CFG_SIGMA_MULTIPLIER: sigma_multiplier <= cfg_data[K_W-1:0];
        CFG_THRESHOLD_FLOOR:  threshold_floor  <= cfg_data[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      mean     <= '0;
      variance <= VAR_ONE;
      thresh   <= THRESH_RESET;
      wcnt     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take && warm) begin
            wcnt <= wcnt + 1'b1;
            if (first) begin
              mean     <= x;
              variance <= VAR_ONE;
            end
          end
        end
        S_VDIFF: begin
          mean <= mean_up ? mean + prod[MEAN_W+GAIN_W-1:GAIN_W]
                          : mean - prod[MEAN_W+GAIN_W-1:GAIN_W];
        end
        S_VUPD: begin
          variance <= var_up ? variance + vstep : variance - vstep;
        end
        S_THR: begin
          thresh <= tfin;
        end
        default: begin
        end
      endcase
    end
  end

  // per-sample work registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          sample_r <= sample;
          gain     <= warm ? fast_gain : slow_gain;
          steady   <= !warm;
          need_thr <= need_thr_c;
          alarm_r  <= 1'b0;
          mean_up  <= x >= mean;
          mag      <= (x >= mean) ? x - mean : mean - x;
        end
      end
      S_MEAN: begin
        e2 <= prod[PROD_W-1:GAIN_W];
      end
      S_VDIFF: begin
        var_up <= e2 >= variance;
        vd     <= (e2 >= variance) ? e2 - variance : variance - e2;
      end
      S_VHI: begin
        vlo_hi <= prod[ROOT_W+GAIN_W-1:GAIN_W];
      end
      S_THR: begin
        alarm_r <= steady && (sample_r > tfin);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      alarm         <= alarm_r;
      learned       <= wcnt >= warmup_count;
      threshold_out <= thresh;
      mean_out      <= mean[MEAN_W-1:FRAC_SH];
    end
  end

  // a sample always leaves the idle state the cycle after it is taken
  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state != S_IDLE))
    else $error("sequencer stayed idle after taking a sample");

  // the root handed to the scale step is the floor square root
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_KMUL) |->
      (({20'b0, sq_root} * {20'b0, sq_root}) <= variance) &&
      ((({21'b0, sq_root} + 41'd1) * ({21'b0, sq_root} + 41'd1)) > {1'b0, variance}))
    else $error("square root result out of range");

  // a freshly computed threshold never sits below the floor
  a_thresh_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_THR) |=> (thresh >= threshold_floor))
    else $error("threshold below floor");

  // an alarm word always reports warm-up as complete
  a_alarm_learned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!alarm || learned))
    else $error("alarm raised during warm-up");

endmodule

`default_nettype wire
